/* design/ajf_pkg.sv */
// ----------------------------------------------------------------------------
// ajf_pkg
// shared types and constants for the jerk and up-face block
// ----------------------------------------------------------------------------
package ajf_pkg;

  localparam int unsigned TIME_W  = 16;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned JERK_W  = 16;
  localparam int unsigned FACE_W  = 3;

  typedef logic [FACE_W-1:0]  face_t;
  typedef logic [SCALE_W-1:0] scale_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [JERK_W-1:0]  jerk_t;

  localparam scale_t SCALE_RESET = 16'd1000;

  localparam face_t FACE_POS_Y = 3'd0;
  localparam face_t FACE_NEG_X = 3'd1;
  localparam face_t FACE_POS_Z = 3'd2;
  localparam face_t FACE_NEG_Z = 3'd3;
  localparam face_t FACE_POS_X = 3'd4;
  localparam face_t FACE_NEG_Y = 3'd5;

  localparam jerk_t JERK_MAX = 16'h7FFF;
  localparam jerk_t JERK_MIN = 16'h8000;

endpackage

/* design/accel_jerk_and_face.sv */
// ----------------------------------------------------------------------------
// accel_jerk_and_face
// jerk per axis and up face from a timestamped three-axis accelerometer stream
// ----------------------------------------------------------------------------
// Each accepted sample gives one result: per-axis jerk, the change from the
// previous sample times the gain over the signed wrapped elapsed ms,
// truncated toward zero and saturated to 16 bits, plus the up face from the
// raw counts. The front stage accepts a sample while the queue is not full and
// queues up to two; the back stage runs the shared three-lane restoring
// divider, which retires one quotient bit per cycle over the SAMPLE_BITS + 16
// bit scaled delta. A held result does not stop the next sample being divided.
// The user must write the gain through cfg_wr_en / cfg_wr_data only while the
// block is idle; the block does not enforce it. The gain resets to 1000.
// ----------------------------------------------------------------------------
module accel_jerk_and_face #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  ajf_pkg::scale_t      cfg_wr_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // accel_x, accel_y, accel_z, time_ms, zero pad
  input  logic [((3*SAMPLE_BITS+ajf_pkg::TIME_W+7)/8)*8-1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // face, jerk_x, jerk_y, jerk_z, zero pad
  output logic [((ajf_pkg::FACE_W+3*ajf_pkg::JERK_W+7)/8)*8-1:0] out_tdata,
  // zero_elapsed
  output logic                 out_tuser
);
  import ajf_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned JOB_W = 3*(SB+1) + TIME_W + FACE_W + 2;
  localparam int unsigned OUT_W = FACE_W + 3*JERK_W;
  localparam int unsigned OUT_B = ((OUT_W + 7) / 8) * 8;

  scale_t             scale_r, scale_nxt;
  logic               q_full, q_push, q_pop, q_valid;
  logic [JOB_W-1:0]   q_job_in, q_job_out;
  face_t              face;
  jerk_t              jerk_x, jerk_y, jerk_z;

  assign scale_nxt = cfg_wr_en ? cfg_wr_data : scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else begin
      scale_r <= scale_nxt;
    end
  end

  ajf_front #(.SAMPLE_BITS(SB)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .accel_x  (in_tdata[SB-1:0]),
    .accel_y  (in_tdata[2*SB-1:SB]),
    .accel_z  (in_tdata[3*SB-1:2*SB]),
    .time_ms  (in_tdata[3*SB+TIME_W-1:3*SB]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job_in)
  );

  ajf_queue #(.WIDTH(JOB_W)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_job_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_job_out)
  );

  ajf_back #(.SAMPLE_BITS(SB)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .gain             (scale_r),
    .q_valid          (q_valid),
    .q_job            (q_job_out),
    .q_pop            (q_pop),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_face         (face),
    .out_jerk_x       (jerk_x),
    .out_jerk_y       (jerk_y),
    .out_jerk_z       (jerk_z),
    .out_zero_elapsed (out_tuser)
  );

  assign out_tdata = OUT_B'({jerk_z, jerk_y, jerk_x, face});

endmodule

/* design/ajf_front.sv */
// ----------------------------------------------------------------------------
// ajf_front
// takes samples, forms deltas, elapsed time and up face, keeps the previous one
// ----------------------------------------------------------------------------
module ajf_front #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_BITS-1:0]   accel_x,
  input  logic [SAMPLE_BITS-1:0]   accel_y,
  input  logic [SAMPLE_BITS-1:0]   accel_z,
  input  ajf_pkg::time_t           time_ms,
  input  logic                     q_full,
  output logic                     q_push,
  output logic [3*(SAMPLE_BITS+1)+ajf_pkg::TIME_W+ajf_pkg::FACE_W+1:0] q_job
);
  import ajf_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned DW = SB + 1;

  logic [SB-1:0] prev_r   [3];
  logic [SB-1:0] prev_nxt [3];
  time_t         prev_time_r, prev_time_nxt;

  logic [SB-1:0] smp  [3];
  logic [DW-1:0] dlt  [3];
  logic [DW-1:0] dneg [3];
  logic [SB-1:0] dmag [3];
  logic [SB-1:0] amag [3];
  logic [SB-1:0] sneg [3];
  logic          spos [3];
  time_t         dt, dt_mag;
  logic          dt_zero;
  face_t         face;

  assign smp[0] = accel_x;
  assign smp[1] = accel_y;
  assign smp[2] = accel_z;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dlt[i]  = {smp[i][SB-1], smp[i]} - {prev_r[i][SB-1], prev_r[i]};
      dneg[i] = ~dlt[i] + DW'(1);
      dmag[i] = dlt[i][SB] ? dneg[i][SB-1:0] : dlt[i][SB-1:0];
      sneg[i] = ~smp[i] + SB'(1);
      amag[i] = smp[i][SB-1] ? sneg[i] : smp[i];
      spos[i] = !smp[i][SB-1] && (smp[i] != '0);
    end
  end

  assign dt      = time_ms - prev_time_r;
  assign dt_zero = (dt == '0);
  assign dt_mag  = dt[TIME_W-1] ? (~dt + TIME_W'(1)) : dt;

  // up face from raw count magnitudes; ties favour y, then z, then x
  always_comb begin
    if (amag[0] > amag[1]) begin
      if (amag[0] > amag[2]) begin
        face = spos[0] ? FACE_POS_X : FACE_NEG_X;
      end else begin
        face = spos[2] ? FACE_POS_Z : FACE_NEG_Z;
      end
    end else if (amag[2] > amag[1]) begin
      face = spos[2] ? FACE_POS_Z : FACE_NEG_Z;
    end else begin
      face = spos[1] ? FACE_POS_Y : FACE_NEG_Y;
    end
  end

  assign q_job = {face, dt_zero, dt[TIME_W-1], dt_mag,
                  dlt[2][SB], dmag[2], dlt[1][SB], dmag[1], dlt[0][SB], dmag[0]};

  always_comb begin
    prev_time_nxt = prev_time_r;
    for (int i = 0; i < 3; i++) begin
      prev_nxt[i] = prev_r[i];
    end
    if (q_push) begin
      prev_time_nxt = time_ms;
      for (int i = 0; i < 3; i++) begin
        prev_nxt[i] = smp[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_time_r <= '0;
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= '0;
      end
    end else begin
      prev_time_r <= prev_time_nxt;
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= prev_nxt[i];
      end
    end
  end

endmodule

/* design/ajf_queue.sv */
// ----------------------------------------------------------------------------
// ajf_queue
// two-entry request queue between front and back, head always in slot 0
// ----------------------------------------------------------------------------
module ajf_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  logic             vld_r   [2];
  logic             vld_nxt [2];
  logic [WIDTH-1:0] dat_r   [2];
  logic [WIDTH-1:0] dat_nxt [2];

  assign full       = vld_r[1];
  assign head_valid = vld_r[0];
  assign head_data  = dat_r[0];

  always_comb begin
    vld_nxt[0] = vld_r[0];
    vld_nxt[1] = vld_r[1];
    dat_nxt[0] = dat_r[0];
    dat_nxt[1] = dat_r[1];
    if (pop) begin
      vld_nxt[0] = vld_r[1];
      dat_nxt[0] = dat_r[1];
      vld_nxt[1] = 1'b0;
    end
    if (push) begin
      if (vld_nxt[0]) begin
        vld_nxt[1] = 1'b1;
        dat_nxt[1] = push_data;
      end else begin
        vld_nxt[0] = 1'b1;
        dat_nxt[0] = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
      vld_r[1] <= 1'b0;
    end else begin
      vld_r[0] <= vld_nxt[0];
      vld_r[1] <= vld_nxt[1];
    end
    dat_r[0] <= dat_nxt[0];
    dat_r[1] <= dat_nxt[1];
  end

endmodule

/* design/ajf_back.sv */
// ----------------------------------------------------------------------------
// ajf_back
// scales deltas, divides by elapsed time bit-serially, saturates, holds result
// ----------------------------------------------------------------------------
module ajf_back #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ajf_pkg::scale_t      gain,
  input  logic                 q_valid,
  input  logic [3*(SAMPLE_BITS+1)+ajf_pkg::TIME_W+ajf_pkg::FACE_W+1:0] q_job,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ajf_pkg::face_t       out_face,
  output ajf_pkg::jerk_t       out_jerk_x,
  output ajf_pkg::jerk_t       out_jerk_y,
  output ajf_pkg::jerk_t       out_jerk_z,
  output logic                 out_zero_elapsed
);
  import ajf_pkg::*;

  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned LW   = SB + 1;
  localparam int unsigned PW   = SB + SCALE_W;
  localparam int unsigned CW   = $clog2(PW);
  localparam int unsigned DT_O = 3 * LW;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [SB-1:0]     mag_r [3], mag_nxt [3];
  logic              sgn_r [3], sgn_nxt [3];
  logic [PW-1:0]     quo_r [3], quo_nxt [3];
  logic [TIME_W-1:0] rem_r [3], rem_nxt [3];
  time_t             div_r, div_nxt;
  logic              dsgn_r, dsgn_nxt;
  logic              zero_r, zero_nxt;
  face_t             face_r, face_nxt;
  logic              ovld_r, ovld_nxt;
  jerk_t             jerk_r [3], jerk_nxt [3];
  face_t             oface_r, oface_nxt;
  logic              ozero_r, ozero_nxt;

  logic [TIME_W:0]   trial [3];
  logic              out_free;
  logic              neg   [3];
  jerk_t             qlo   [3];
  jerk_t             sat   [3];

  assign out_free  = !ovld_r || out_ready;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;

  assign out_valid        = ovld_r;
  assign out_face         = oface_r;
  assign out_jerk_x       = jerk_r[0];
  assign out_jerk_y       = jerk_r[1];
  assign out_jerk_z       = jerk_r[2];
  assign out_zero_elapsed = ozero_r;

  // truncated quotient magnitude to saturated signed result
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i] = sgn_r[i] ^ dsgn_r;
      qlo[i] = quo_r[i][JERK_W-1:0];
      if (zero_r) begin
        sat[i] = '0;
      end else if (neg[i]) begin
        if ((quo_r[i][PW-1:JERK_W] != '0) ||
            (quo_r[i][JERK_W-1] && (quo_r[i][JERK_W-2:0] != '0))) begin
          sat[i] = JERK_MIN;
        end else begin
          sat[i] = ~qlo[i] + JERK_W'(1);
        end
      end else if (quo_r[i][PW-1:JERK_W-1] != '0) begin
        sat[i] = JERK_MAX;
      end else begin
        sat[i] = qlo[i];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    div_nxt   = div_r;
    dsgn_nxt  = dsgn_r;
    zero_nxt  = zero_r;
    face_nxt  = face_r;
    ovld_nxt  = ovld_r;
    oface_nxt = oface_r;
    ozero_nxt = ozero_r;
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i]  = mag_r[i];
      sgn_nxt[i]  = sgn_r[i];
      quo_nxt[i]  = quo_r[i];
      rem_nxt[i]  = rem_r[i];
      jerk_nxt[i] = jerk_r[i];
      trial[i]    = {rem_r[i], quo_r[i][PW-1]};
    end

    if (ovld_r && out_ready) begin
      ovld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          for (int i = 0; i < 3; i++) begin
            mag_nxt[i] = q_job[i*LW +: SB];
            sgn_nxt[i] = q_job[i*LW + SB];
          end
          div_nxt   = q_job[DT_O +: TIME_W];
          dsgn_nxt  = q_job[DT_O + TIME_W];
          zero_nxt  = q_job[DT_O + TIME_W + 1];
          face_nxt  = q_job[DT_O + TIME_W + 2 +: FACE_W];
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        for (int i = 0; i < 3; i++) begin
          quo_nxt[i] = PW'(mag_r[i]) * PW'(gain);
          rem_nxt[i] = '0;
        end
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (trial[i] >= {1'b0, div_r}) begin
            rem_nxt[i] = TIME_W'(trial[i] - {1'b0, div_r});
            quo_nxt[i] = {quo_r[i][PW-2:0], 1'b1};
          end else begin
            rem_nxt[i] = trial[i][TIME_W-1:0];
            quo_nxt[i] = {quo_r[i][PW-2:0], 1'b0};
          end
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(PW - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          for (int i = 0; i < 3; i++) begin
            jerk_nxt[i] = sat[i];
          end
          oface_nxt = face_r;
          ozero_nxt = zero_r;
          ovld_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
    cnt_r   <= cnt_nxt;
    div_r   <= div_nxt;
    dsgn_r  <= dsgn_nxt;
    zero_r  <= zero_nxt;
    face_r  <= face_nxt;
    oface_r <= oface_nxt;
    ozero_r <= ozero_nxt;
    for (int i = 0; i < 3; i++) begin
      mag_r[i]  <= mag_nxt[i];
      sgn_r[i]  <= sgn_nxt[i];
      quo_r[i]  <= quo_nxt[i];
      rem_r[i]  <= rem_nxt[i];
      jerk_r[i] <= jerk_nxt[i];
    end
  end

endmodule
